>>> rtl/core/rpa_pkg.sv
// Shared types and constants for the register pool allocator.
// Depends on nothing; every module of the block imports it.
package rpa_pkg;

  // Pool geometry.
  localparam int POOL_SIZE = 32;
  localparam int IDX_W     = $clog2(POOL_SIZE);
  localparam int PTR_W     = $clog2(POOL_SIZE + 1);
  localparam int SLOT_W    = IDX_W + 1;
  localparam int OUT_IDX_W = 5;
  localparam int REQ_IDX_W = 6;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_FIND = 2'd0,
    REQ_MARK = 2'd1,
    REQ_FREE = 2'd2,
    REQ_LIST = 2'd3
  } req_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic scan;
    logic flush;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
  } status_t;

endpackage

>>> rtl/core/rpa_ctrl.sv
// Controller state machine of the register pool allocator.
// Depends on rpa_pkg for the command, status and request types.
module rpa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  rpa_pkg::req_t    req,
  input  rpa_pkg::status_t status,
  output rpa_pkg::cmd_t    cmd,
  output logic             busy
);
  import rpa_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);

  // Next state: single-word requests pass through the execute state, a list
  // request walks every slot and then flushes its held word.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (req == REQ_LIST) ? ST_SCAN : ST_EXEC;
        end
      end
      ST_EXEC:  state_next = ST_IDLE;
      ST_SCAN: begin
        if (status.scan_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Commands follow directly from the state; load is a start taken in idle.
  assign cmd.load  = accept;
  assign cmd.exec  = (state == ST_EXEC);
  assign cmd.scan  = (state == ST_SCAN);
  assign cmd.flush = (state == ST_FLUSH);

endmodule

>>> rtl/core/rpa_dp.sv
// Datapath of the register pool allocator: bitmaps, search pointers,
// rotating free search, list walk and the result register. Uses rpa_pkg.
module rpa_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  rpa_pkg::cmd_t                     cmd,
  input  rpa_pkg::req_t                     req,
  input  logic                              cls,
  input  logic [rpa_pkg::REQ_IDX_W-1:0]     idx,
  output rpa_pkg::status_t                  status,
  output logic                              done,
  output logic                              ok,
  output logic                              out_class,
  output logic [rpa_pkg::OUT_IDX_W-1:0]     out_index,
  output logic                              last
);
  import rpa_pkg::*;

  // Bitmaps and search pointers.
  logic [POOL_SIZE-1:0] int_map;
  logic [POOL_SIZE-1:0] flt_map;
  logic [PTR_W-1:0]     int_ptr;
  logic [PTR_W-1:0]     flt_ptr;

  // Latched request.
  req_t                 rq_type;
  logic                 rq_class;
  logic [REQ_IDX_W-1:0] rq_index;

  // List walk state: slot counter and one held word.
  logic [SLOT_W-1:0]    slot;
  logic                 pend_valid;
  logic                 pend_class;
  logic [IDX_W-1:0]     pend_index;

  // Search and single-request signals.
  logic [POOL_SIZE-1:0] sel_map;
  logic [PTR_W-1:0]     sel_ptr;
  logic [IDX_W-1:0]     start_pos;
  logic [POOL_SIZE-1:0] free_v;
  logic [POOL_SIZE-1:0] upper_v;
  logic                 hi_found;
  logic [IDX_W-1:0]     hi_idx;
  logic                 lo_found;
  logic [IDX_W-1:0]     lo_idx;
  logic                 find_ok;
  logic [IDX_W-1:0]     find_idx;
  logic [PTR_W-1:0]     ptr_next;
  logic                 in_range;
  logic [IDX_W-1:0]     rq_idx_low;
  logic                 cur_bit;
  logic                 single_ok;
  logic [IDX_W-1:0]     single_idx;

  // Scan signals.
  logic [IDX_W-1:0]     scan_idx;
  logic                 scan_int;
  logic                 scan_used;

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rq_type  <= req;
      rq_class <= cls;
      rq_index <= idx;
    end
  end

  // Rotating free search: first free bit at or above the pointer,
  // otherwise the first free bit from the bottom.
  always_comb begin
    sel_map   = rq_class ? int_map : flt_map;
    sel_ptr   = rq_class ? int_ptr : flt_ptr;
    start_pos = (sel_ptr >= PTR_W'(POOL_SIZE)) ? '0 : sel_ptr[IDX_W-1:0];
    free_v    = ~sel_map;
    for (int k = 0; k < POOL_SIZE; k++) begin
      upper_v[k] = free_v[k] && (IDX_W'(k) >= start_pos);
    end
    hi_found = |upper_v;
    lo_found = |free_v;
    hi_idx   = '0;
    lo_idx   = '0;
    for (int k = POOL_SIZE - 1; k >= 0; k--) begin
      if (upper_v[k]) begin
        hi_idx = IDX_W'(k);
      end
      if (free_v[k]) begin
        lo_idx = IDX_W'(k);
      end
    end
    find_ok  = lo_found;
    find_idx = hi_found ? hi_idx : lo_idx;
    ptr_next = PTR_W'(find_idx) + PTR_W'(1);
  end

  // Find, mark and free checks.
  always_comb begin
    in_range   = (rq_index < REQ_IDX_W'(POOL_SIZE));
    rq_idx_low = rq_index[IDX_W-1:0];
    cur_bit    = sel_map[rq_idx_low];
    single_idx = in_range ? rq_idx_low : '0;
    case (rq_type)
      REQ_FIND: begin
        single_ok  = find_ok;
        single_idx = find_ok ? find_idx : '0;
      end
      REQ_MARK: single_ok = in_range && !cur_bit;
      REQ_FREE: single_ok = in_range && cur_bit;
      default:  single_ok = 1'b0;
    endcase
  end

  // Slot decode: even slots are integer registers, odd slots float; the
  // top two integer registers are never listed.
  always_comb begin
    scan_idx  = slot[SLOT_W-1:1];
    scan_int  = !slot[0];
    scan_used = scan_int ? (int_map[scan_idx] && (scan_idx < IDX_W'(POOL_SIZE - 2)))
                         : flt_map[scan_idx];
    status.scan_last = (slot == SLOT_W'(2 * POOL_SIZE - 1));
  end

  // Bitmaps and pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      int_map <= '0;
      flt_map <= '0;
      int_ptr <= '0;
      flt_ptr <= '0;
    end else if (cmd.exec) begin
      case (rq_type)
        REQ_FIND: begin
          if (find_ok) begin
            if (rq_class) begin
              int_ptr <= ptr_next;
            end else begin
              flt_ptr <= ptr_next;
            end
          end
        end
        REQ_MARK, REQ_FREE: begin
          if (single_ok) begin
            if (rq_class) begin
              int_map[rq_idx_low] <= (rq_type == REQ_MARK);
            end else begin
              flt_map[rq_idx_low] <= (rq_type == REQ_MARK);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // List walk: one slot a cycle; a found word is held until the next one
  // shows up, so the final word can carry the last flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot       <= '0;
      pend_valid <= 1'b0;
    end else if (cmd.load) begin
      slot       <= '0;
      pend_valid <= 1'b0;
    end else if (cmd.scan) begin
      slot <= slot + SLOT_W'(1);
      if (scan_used) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && scan_used) begin
      pend_class <= scan_int;
      pend_index <= scan_idx;
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec || cmd.flush || (cmd.scan && scan_used && pend_valid);
    end
  end

  // Result word.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok        <= single_ok;
      out_class <= rq_class;
      out_index <= OUT_IDX_W'(single_idx);
      last      <= 1'b1;
    end else if (cmd.flush) begin
      ok        <= pend_valid;
      out_class <= pend_valid && pend_class;
      out_index <= pend_valid ? OUT_IDX_W'(pend_index) : '0;
      last      <= 1'b1;
    end else if (cmd.scan && scan_used && pend_valid) begin
      ok        <= 1'b1;
      out_class <= pend_class;
      out_index <= OUT_IDX_W'(pend_index);
      last      <= 1'b0;
    end
  end

endmodule

>>> rtl/core/register_pool_allocator.sv
// Top level of the register pool allocator: controller plus datapath.
// Depends on rpa_pkg, rpa_ctrl and rpa_dp.
//
//   channel   handshake          word
//   -------   ----------------   ------------------------------------
//   request   start / busy       req_type, reg_class, reg_index
//   result    done (strobe)      ok, out_class, out_index, last
//
// Find, mark and free latch the request, then run the rotating search or
// the bit update in the execute state, which registers the result word.
// A list request walks 2*POOL_SIZE slots one per cycle, then a flush state;
// each word comes out once the next is found, the last one at the flush.
// Synchronous reset clears both bitmaps and pointers; no clearing pass.
// Each word is on the outputs for one cycle; the receiver cannot stall it.
module register_pool_allocator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        req_type,
  input  logic                              reg_class,
  input  logic [rpa_pkg::REQ_IDX_W-1:0]     reg_index,
  output logic                              done,
  output logic                              ok,
  output logic                              out_class,
  output logic [rpa_pkg::OUT_IDX_W-1:0]     out_index,
  output logic                              last
);
  import rpa_pkg::*;

  cmd_t    cmd;
  status_t status;
  req_t    req;

  assign req = req_t'(req_type);

  // Controller.
  rpa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Datapath.
  rpa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .cls       (reg_class),
    .idx       (reg_index),
    .status    (status),
    .done      (done),
    .ok        (ok),
    .out_class (out_class),
    .out_index (out_index),
    .last      (last)
  );

`ifndef SYNTHESIS
  // A word without the last flag belongs to a list still in progress.
  a_mid_list_busy: assert property (@(posedge clk) disable iff (rst)
    (done && !last) |-> busy)
    else $error("non-final word while idle");

  // Only the final word of a list may report failure.
  a_mid_list_ok: assert property (@(posedge clk) disable iff (rst)
    (done && !last) |-> ok)
    else $error("non-final word without ok");

  // A single-word request stays busy with no word while it executes, then answers as last.
  a_single_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req_type != REQ_LIST)) |=> (busy && !done) ##1 (done && last))
    else $error("single request answer timing");
`endif

endmodule

>>> tb/allocator_checker.sv
// Checker for the register pool allocator: watches the request and result channels,
// predicts every result word from its own copy of the bitmaps and pointers, and compares.
// Depends on rpa_pkg for the pool size, field widths and request codes.
`timescale 1ns / 100ps

module allocator_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [1:0]                    req_type,
  input  logic                          reg_class,
  input  logic [rpa_pkg::REQ_IDX_W-1:0] reg_index,
  input  logic                          done,
  input  logic                          ok,
  input  logic                          out_class,
  input  logic [rpa_pkg::OUT_IDX_W-1:0] out_index,
  input  logic                          last,
  output int                            mismatches,
  output int                            pending,
  output int                            words_checked
);
  import rpa_pkg::*;

  // One result word as the block reports it.
  typedef struct packed {
    logic                 ok;
    logic                 cls;
    logic [OUT_IDX_W-1:0] idx;
    logic                 last;
  } word_t;

  word_t                expected_words[$];
  logic [POOL_SIZE-1:0] int_used;
  logic [POOL_SIZE-1:0] flt_used;
  logic [PTR_W-1:0]     int_ptr;
  logic [PTR_W-1:0]     flt_ptr;
  int                   err_count = 0;
  int                   word_count = 0;
  int                   queue_depth = 0;

  assign mismatches    = err_count;
  assign words_checked = word_count;
  assign pending       = queue_depth;

  function automatic word_t pack_word(logic w_ok, logic w_cls, int w_idx, logic w_last);
    word_t w;
    w.ok   = w_ok;
    w.cls  = w_cls;
    w.idx  = OUT_IDX_W'(w_idx);
    w.last = w_last;
    return w;
  endfunction

  // Appends one predicted word at the tail of the queue.
  function automatic void add_expected(word_t w);
    expected_words.insert(expected_words.size(), w);
  endfunction

  // Reports one field and returns 1 when it differs.
  function automatic bit field_differs(string name, int seq, int want, int got);
    if (want != got) begin
      $display("%0t: word %0d field %s expected %0d, got %0d", $time, seq, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Works out the words that one accepted request will produce and updates the pools.
  task automatic predict_request(input req_t rq, input logic cls,
                                 input logic [REQ_IDX_W-1:0] idx);
    logic [POOL_SIZE-1:0] map;
    logic                 success;
    int                   base;
    int                   p;
    int                   n;
    int                   k;
    int                   found;
    map = cls ? int_used : flt_used;
    case (rq)
      // Round-robin search from the pool's pointer; the bit is left clear.
      REQ_FIND: begin
        base  = int'(cls ? int_ptr : flt_ptr) % POOL_SIZE;
        found = -1;
        for (k = 0; k < POOL_SIZE && found < 0; k++) begin
          p = (base + k) % POOL_SIZE;
          if (!map[p]) found = p;
        end
        if (found < 0) begin
          add_expected(pack_word(1'b0, cls, 0, 1'b1));
        end else begin
          add_expected(pack_word(1'b1, cls, found, 1'b1));
          if (cls) int_ptr = PTR_W'(found + 1);
          else flt_ptr = PTR_W'(found + 1);
        end
      end
      // Mark needs a clear in-range bit, free a set one.
      REQ_MARK, REQ_FREE: begin
        success = 1'b0;
        if (idx < POOL_SIZE) begin
          if (rq == REQ_MARK && !map[idx]) begin
            map[idx] = 1'b1;
            success  = 1'b1;
          end else if (rq == REQ_FREE && map[idx]) begin
            map[idx] = 1'b0;
            success  = 1'b1;
          end
        end
        if (cls) int_used = map;
        else flt_used = map;
        add_expected(pack_word(success, cls, (idx < POOL_SIZE) ? int'(idx) : 0, 1'b1));
      end
      // List walks ascending indexes, integer before float, skipping the
      // stack and base pointer registers at the top of the integer pool.
      default: begin
        n = 0;
        for (k = 0; k < POOL_SIZE; k++) begin
          if (int_used[k] && k < POOL_SIZE - 2) n++;
          if (flt_used[k]) n++;
        end
        if (n == 0) begin
          add_expected(pack_word(1'b0, 1'b0, 0, 1'b1));
        end else begin
          p = 0;
          for (k = 0; k < POOL_SIZE; k++) begin
            if (int_used[k] && k < POOL_SIZE - 2) begin
              p++;
              add_expected(pack_word(1'b1, 1'b1, k, p == n));
            end
            if (flt_used[k]) begin
              p++;
              add_expected(pack_word(1'b1, 1'b0, k, p == n));
            end
          end
        end
      end
    endcase
  endtask

  // Results are checked before a request of the same edge is predicted, since
  // a word leaving now always belongs to an earlier request.
  always @(posedge clk) begin : watch
    word_t want;
    bit    bad;
    if (rst) begin
      int_used = '0;
      flt_used = '0;
      int_ptr  = '0;
      flt_ptr  = '0;
      expected_words.delete();
    end else begin
      if (done) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word ok=%0d class=%0d index=%0d last=%0d",
                   $time, ok, out_class, out_index, last);
          err_count++;
        end else begin
          want = expected_words.pop_front();
          bad  = field_differs("ok", word_count, want.ok, ok)
               | field_differs("out_class", word_count, want.cls, out_class)
               | field_differs("out_index", word_count, want.idx, out_index)
               | field_differs("last", word_count, want.last, last);
          if (bad) err_count++;
        end
        word_count++;
      end
      if (start && !busy) predict_request(req_t'(req_type), reg_class, reg_index);
    end
    queue_depth <= expected_words.size();
  end

endmodule

>>> tb/testbench.sv
// Top of the register pool allocator testbench: clock, reset and request stimulus.
// Depends on rpa_pkg, register_pool_allocator and allocator_checker.
`timescale 1ns / 100ps

module testbench;
  import rpa_pkg::*;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int TAIL_CYCLES  = 2 * POOL_SIZE + 8;
  localparam int PHASE_ITEMS  = 115;
  localparam int MAX_GAP      = 40;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic [1:0]           req_type = '0;
  logic                 reg_class = 1'b0;
  logic [REQ_IDX_W-1:0] reg_index = '0;
  logic                 busy;
  logic                 done;
  logic                 ok;
  logic                 out_class;
  logic [OUT_IDX_W-1:0] out_index;
  logic                 last;

  int mismatches;
  int pending;
  int words_checked;
  int idle_pct = 0;
  int items_sent = 0;
  int lists_sent = 0;
  int cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  register_pool_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .reg_class (reg_class),
    .reg_index (reg_index),
    .done      (done),
    .ok        (ok),
    .out_class (out_class),
    .out_index (out_index),
    .last      (last)
  );

  allocator_checker chk (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .reg_class     (reg_class),
    .reg_index     (reg_index),
    .done          (done),
    .ok            (ok),
    .out_class     (out_class),
    .out_index     (out_index),
    .last          (last),
    .mismatches    (mismatches),
    .pending       (pending),
    .words_checked (words_checked)
  );

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d words outstanding",
               $time, cycle_count, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Presents one request, holds it until accepted, then idles at random.
  // While idle the request fields carry junk that the block must ignore.
  task automatic issue(input req_t rq, input logic cls, input logic [REQ_IDX_W-1:0] idx);
    int gap;
    start     <= 1'b1;
    req_type  <= rq;
    reg_class <= cls;
    reg_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (rq == REQ_LIST) lists_sent++;
    gap = 0;
    while (gap < MAX_GAP && int'($urandom_range(99)) < idle_pct) gap++;
    if (gap > 0) begin
      start     <= 1'b0;
      req_type  <= 2'($urandom);
      reg_class <= 1'($urandom);
      reg_index <= REQ_IDX_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random traffic: runs of marks or frees over neighboring registers fill and
  // drain a pool quickly, with finds mixed in; the rest are loose requests.
  task automatic random_traffic(input int count);
    int   target;
    int   sel;
    int   base;
    int   len;
    int   k;
    logic cls;
    req_t rq;
    logic [REQ_IDX_W-1:0] idx;
    target = items_sent + count;
    while (items_sent < target) begin
      sel = $urandom_range(99);
      cls = 1'($urandom);
      if (sel < 45) begin
        base = $urandom_range(POOL_SIZE - 1);
        len  = $urandom_range(POOL_SIZE, 4);
        rq   = (sel < 30) ? REQ_MARK : REQ_FREE;
        for (k = 0; k < len && items_sent < target; k++) begin
          issue(rq, cls, REQ_IDX_W'((base + k) % POOL_SIZE));
          if ($urandom_range(3) == 0) issue(REQ_FIND, cls, REQ_IDX_W'($urandom));
        end
      end else begin
        rq  = req_t'($urandom_range(3));
        idx = ($urandom_range(9) == 0) ? REQ_IDX_W'($urandom_range(63, POOL_SIZE))
                                       : REQ_IDX_W'($urandom_range(POOL_SIZE - 1));
        issue(rq, cls, idx);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty list, finds from reset, duplicate and out-of-range
    // marks and frees, and lists that must skip the top two integer registers.
    issue(REQ_LIST, 1'b1, 6'd0);
    issue(REQ_FIND, 1'b1, 6'd0);
    issue(REQ_FIND, 1'b1, 6'd0);
    issue(REQ_FIND, 1'b0, 6'd63);
    issue(REQ_MARK, 1'b1, 6'd0);
    issue(REQ_MARK, 1'b1, 6'd0);
    issue(REQ_MARK, 1'b1, 6'd31);
    issue(REQ_MARK, 1'b1, 6'd30);
    issue(REQ_MARK, 1'b1, 6'd32);
    issue(REQ_MARK, 1'b0, 6'd63);
    issue(REQ_FREE, 1'b1, 6'd5);
    issue(REQ_FREE, 1'b0, 6'd40);
    issue(REQ_MARK, 1'b0, 6'd31);
    issue(REQ_MARK, 1'b0, 6'd0);
    issue(REQ_LIST, 1'b0, 6'd0);
    issue(REQ_FREE, 1'b1, 6'd31);
    issue(REQ_FREE, 1'b1, 6'd31);
    issue(REQ_MARK, 1'b1, 6'd29);
    issue(REQ_FIND, 1'b1, 6'd0);
    issue(REQ_LIST, 1'b1, 6'd63);

    // Random phases: steady sender, mostly idle sender, lightly idle sender.
    // The receiver cannot stall, so its phase reduces to a steady sender.
    idle_pct = 0;
    random_traffic(PHASE_ITEMS);
    idle_pct = 83;
    random_traffic(PHASE_ITEMS);
    idle_pct = 15;
    random_traffic(PHASE_ITEMS);
    idle_pct = 0;
    random_traffic(PHASE_ITEMS);
    start <= 1'b0;

    // Drain, then give a list time to finish its flush.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d lists) and checked %0d result words,",
             items_sent, lists_sent, words_checked);
    $display("with steady, mostly idle and lightly idle request streams.");
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d bad words, %0d words never seen", mismatches, pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> register_pool_allocator.f
rtl/core/rpa_pkg.sv
rtl/core/rpa_ctrl.sv
rtl/core/rpa_dp.sv
rtl/core/register_pool_allocator.sv
tb/allocator_checker.sv
tb/testbench.sv
